// ===== hw/rtl/tae_pkg.sv =====
package tae_pkg;

    localparam int REGISTER_COUNT = 16;
    localparam int REG_AW = $clog2(REGISTER_COUNT);

    localparam logic [3:0] MODE_ADD = 4'd0;
    localparam logic [3:0] MODE_ADC = 4'd1;
    localparam logic [3:0] MODE_AND = 4'd2;
    localparam logic [3:0] MODE_EOR = 4'd3;
    localparam logic [3:0] MODE_ORR = 4'd4;
    localparam logic [3:0] MODE_BIC = 4'd5;
    localparam logic [3:0] MODE_CMP = 4'd6;
    localparam logic [3:0] MODE_CMN = 4'd7;
    localparam logic [3:0] MODE_MOV = 4'd8;
    localparam logic [3:0] MODE_B   = 4'd9;

    localparam logic [1:0] SRC_REG = 2'd0;
    localparam logic [1:0] SRC_PC  = 2'd1;
    localparam logic [1:0] SRC_SP  = 2'd2;

    localparam logic [REG_AW-1:0] PC_INDEX = REG_AW'(15);
    localparam logic [REG_AW-1:0] SP_INDEX = REG_AW'(13);

    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef struct packed {
        logic [3:0]        mode;
        logic [REG_AW-1:0] dest_reg;
        logic [REG_AW-1:0] first_reg;
        logic [REG_AW-1:0] second_reg;
        logic              use_immediate;
        logic [31:0]       immediate;
        logic [1:0]        first_source;
        logic              set_flags;
        logic              wide;
    } t_in_word;

    typedef struct packed {
        logic [31:0] result_value;
        logic        dest_written;
        logic [3:0]  flags_out;
        logic [31:0] next_pc;
        logic [1:0]  cycles_taken;
    } t_out_word;

endpackage

// ===== hw/rtl/tae_if.sv =====
interface tae_in_if import tae_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface tae_out_if import tae_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/thumb_alu_execute_unit.sv =====
// An accepted word is registered into stage 1, then its result word into the output register.
// Throughput: one word per cycle while the output is not stalled; operand reads use the
// two read ports of the register memory, issued at accept and registered for stage 1.
// The PC and flags sit in flip-flops, so each word sees the previous one's update.
// Reset: i_rst_n low at a clock edge clears PC, flags, register valid bits and
// all pipeline valids; a register never written reads as zero, except r15, which reads as PC+4.
module thumb_alu_execute_unit import tae_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tae_in_if.sink   i_in,
    tae_out_if.source o_out
);

    logic [31:0]         r_mem [REGISTER_COUNT];
    logic [31:0]         r_rd_a;
    logic [31:0]         r_rd_b;
    logic [REGISTER_COUNT-1:0] r_valid;

    logic                r_fwd_en;
    logic [REG_AW-1:0]   r_fwd_addr;
    logic [31:0]         r_fwd_data;

    logic                r_s1_valid;
    t_in_word            r_s1;
    logic [REG_AW-1:0]   r_s1_addr_a;

    logic                r_out_valid;
    t_out_word           r_out;

    logic [31:0]         r_pc;
    logic [3:0]          r_flags;

    logic                s1_adv;
    logic                in_acc;
    logic [REG_AW-1:0]   rd_addr_a;

    logic [31:0]         pc4;
    logic [31:0]         a_reg;
    logic [31:0]         b_reg;
    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [31:0]         add_b;
    logic                add_cin;
    logic [32:0]         sum;
    logic                add_v;

    logic [31:0]         n_result;
    logic                n_writes;
    logic                n_arith;
    logic                n_logic;
    logic [3:0]          n_flags;
    logic [31:0]         n_pc;
    logic [1:0]          n_cycles;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;
    assign rd_addr_a  = (i_in.data.first_source == SRC_SP) ? SP_INDEX : i_in.data.first_reg;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[i_in.data.second_reg];
        end
        if (s1_adv && n_writes && r_s1.dest_reg != PC_INDEX) begin
            r_mem[r_s1.dest_reg] <= n_result;
        end
    end

    assign pc4 = r_pc + 32'd4;

    always_comb begin
        if (r_s1_addr_a == PC_INDEX) begin
            a_reg = pc4;
        end else if (r_fwd_en && r_fwd_addr == r_s1_addr_a) begin
            a_reg = r_fwd_data;
        end else if (r_valid[r_s1_addr_a]) begin
            a_reg = r_rd_a;
        end else begin
            a_reg = 32'd0;
        end

        if (r_s1.second_reg == PC_INDEX) begin
            b_reg = pc4;
        end else if (r_fwd_en && r_fwd_addr == r_s1.second_reg) begin
            b_reg = r_fwd_data;
        end else if (r_valid[r_s1.second_reg]) begin
            b_reg = r_rd_b;
        end else begin
            b_reg = 32'd0;
        end

        op_a = (r_s1.first_source == SRC_PC) ? pc4 : a_reg;
        op_b = r_s1.use_immediate ? r_s1.immediate : b_reg;

        case (r_s1.mode)
            MODE_ADC: begin
                add_b   = op_b;
                add_cin = r_flags[FLAG_C];
            end
            MODE_CMP: begin
                add_b   = ~op_b;
                add_cin = 1'b1;
            end
            default: begin
                add_b   = op_b;
                add_cin = 1'b0;
            end
        endcase
        sum   = {1'b0, op_a} + {1'b0, add_b} + {32'd0, add_cin};
        add_v = ~(op_a[31] ^ add_b[31]) & (op_a[31] ^ sum[31]);

        n_result = 32'd0;
        n_writes = 1'b0;
        n_arith  = 1'b0;
        n_logic  = 1'b0;
        n_pc     = r_pc + (r_s1.wide ? 32'd4 : 32'd2);
        n_cycles = 2'd1;
        case (r_s1.mode)
            MODE_ADD, MODE_ADC: begin
                n_result = sum[31:0];
                n_arith  = 1'b1;
                n_writes = 1'b1;
            end
            MODE_CMP, MODE_CMN: begin
                n_result = sum[31:0];
                n_arith  = 1'b1;
            end
            MODE_AND: begin
                n_result = op_a & op_b;
                n_logic  = 1'b1;
                n_writes = 1'b1;
            end
            MODE_EOR: begin
                n_result = op_a ^ op_b;
                n_logic  = 1'b1;
                n_writes = 1'b1;
            end
            MODE_ORR: begin
                n_result = op_a | op_b;
                n_logic  = 1'b1;
                n_writes = 1'b1;
            end
            MODE_BIC: begin
                n_result = op_a & ~op_b;
                n_logic  = 1'b1;
                n_writes = 1'b1;
            end
            MODE_MOV: begin
                n_result = op_b;
                n_logic  = 1'b1;
                n_writes = 1'b1;
            end
            MODE_B: begin
                n_result = pc4 + r_s1.immediate;
                n_pc     = pc4 + r_s1.immediate;
                n_cycles = 2'd2;
            end
            default: begin
            end
        endcase

        if (n_writes && r_s1.dest_reg == PC_INDEX) begin
            n_pc     = n_result;
            n_cycles = 2'd2;
        end

        n_flags = r_flags;
        if ((r_s1.set_flags || n_arith && r_s1.mode != MODE_ADD && r_s1.mode != MODE_ADC)
            && (n_arith || n_logic)) begin
            if (n_arith) begin
                n_flags[FLAG_C] = sum[32];
                n_flags[FLAG_V] = add_v;
            end
            n_flags[FLAG_N] = n_result[31];
            n_flags[FLAG_Z] = (n_result == 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_fwd_en    <= 1'b0;
            r_pc        <= 32'd0;
            r_flags     <= 4'd0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_pc    <= n_pc;
                r_flags <= n_flags;
                if (n_writes && r_s1.dest_reg != PC_INDEX) begin
                    r_valid[r_s1.dest_reg] <= 1'b1;
                    r_fwd_en               <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1        <= i_in.data;
            r_s1_addr_a <= rd_addr_a;
        end
        if (s1_adv) begin
            if (n_writes && r_s1.dest_reg != PC_INDEX) begin
                r_fwd_addr <= r_s1.dest_reg;
                r_fwd_data <= n_result;
            end
            r_out.result_value <= n_result;
            r_out.dest_written <= n_writes;
            r_out.flags_out    <= n_flags;
            r_out.next_pc      <= n_pc;
            r_out.cycles_taken <= n_cycles;
        end
    end

endmodule
